[hw/rtl/cfd_pkg.sv]
// Shared types and constants for the command frame deframer.
// Used by hw/rtl/command_frame_deframer.sv; depends on nothing.
package cfd_pkg;

   localparam logic [7:0]  SYNC_BYTE       = 8'h55;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

   // Item kinds on the request channel
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Result kinds on the response channel
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT  = 2'd2;

   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_CMD  = 7'b0000010,
      PH_ID   = 7'b0000100,
      PH_LEN  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_CRC1 = 7'b0100000,
      PH_CRC2 = 7'b1000000
   } phase_type;

endpackage

[hw/rtl/command_frame_deframer.sv]
// Sync-byte, length-prefixed command frame parser with tick-based timeout.
// Depends on hw/rtl/cfd_pkg.sv.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  req     | in        | req_valid/req_stall | req_func, req_data_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_event_kind, frame fields, crc
//  csr     | in        | csr_valid/csr_ready | csr_timeout_ticks
//
// One item per cycle sustained while rsp_stall is low; results leave through the result register.
// An input register feeds the parser step, which loads the result register.
// rsp_stall holds the result register and, through it, the input register and req_stall.
// Synchronous active-high reset: parser hunts, holds clear, timeout_ticks returns to 1000.
// csr_ready is always high; write only while no item is in flight.
module command_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_frame_cmd,
   output logic [7:0]  rsp_frame_id,
   output logic [7:0]  rsp_payload_length,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_frame_crc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks
);

   // Input register
   logic                in_valid_ff, in_valid_in;
   logic                in_func_ff;
   logic [7:0]          in_byte_ff;

   // Parser state
   cfd_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [7:0]          id_ff, id_in;
   logic [7:0]          len_ff, len_in;
   logic [7:0]          count_ff, count_in;
   logic [15:0]         crc_ff, crc_in;
   logic [15:0]         elapsed_ff, elapsed_in;
   logic [15:0]         timeout_ff;

   // Result register
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          o_cmd_ff, o_id_ff, o_len_ff;
   logic [7:0]          o_index_ff, o_index_in;
   logic [7:0]          o_byte_ff, o_byte_in;
   logic [15:0]         o_crc_ff, o_crc_in;

   logic                req_accept;
   logic                advance;
   logic                emit;
   logic [15:0]         elapsed_inc;

   assign advance    = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? emit : (out_valid_ff & rsp_stall);

   assign elapsed_inc = (elapsed_ff == cfd_pkg::TICKS_MAX) ? elapsed_ff
                                                            : elapsed_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      elapsed_in = elapsed_ff;
      emit       = 1'b0;
      kind_in    = cfd_pkg::KIND_PAYLOAD;
      o_index_in = count_ff;
      o_byte_in  = 8'd0;
      o_crc_in   = 16'd0;
      if (in_func_ff == cfd_pkg::FUNC_TICK) begin
         // ticks only count inside a frame
         if (phase_ff != cfd_pkg::PH_HUNT) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc > timeout_ff) begin
               emit     = 1'b1;
               kind_in  = cfd_pkg::KIND_TIMEOUT;
               phase_in = cfd_pkg::PH_HUNT;
            end
         end
      end else begin
         case (phase_ff)
            cfd_pkg::PH_HUNT: begin
               if (in_byte_ff == cfd_pkg::SYNC_BYTE) begin
                  cmd_in     = 8'd0;
                  id_in      = 8'd0;
                  len_in     = 8'd0;
                  count_in   = 8'd0;
                  crc_in     = 16'd0;
                  elapsed_in = 16'd0;
                  phase_in   = cfd_pkg::PH_CMD;
               end
            end
            cfd_pkg::PH_CMD: begin
               cmd_in   = in_byte_ff;
               phase_in = cfd_pkg::PH_ID;
            end
            cfd_pkg::PH_ID: begin
               id_in    = in_byte_ff;
               phase_in = cfd_pkg::PH_LEN;
            end
            cfd_pkg::PH_LEN: begin
               len_in   = in_byte_ff;
               // empty payload goes straight to the check word
               phase_in = (in_byte_ff == 8'd0) ? cfd_pkg::PH_CRC1 : cfd_pkg::PH_DATA;
            end
            cfd_pkg::PH_DATA: begin
               emit      = 1'b1;
               kind_in   = cfd_pkg::KIND_PAYLOAD;
               o_byte_in = in_byte_ff;
               count_in  = count_ff + 8'd1;
               if (count_in == len_ff) begin
                  phase_in = cfd_pkg::PH_CRC1;
               end
            end
            cfd_pkg::PH_CRC1: begin
               crc_in   = {in_byte_ff, 8'd0};
               phase_in = cfd_pkg::PH_CRC2;
            end
            cfd_pkg::PH_CRC2: begin
               crc_in   = {crc_ff[15:8], in_byte_ff};
               emit     = 1'b1;
               kind_in  = cfd_pkg::KIND_COMPLETE;
               o_crc_in = {crc_ff[15:8], in_byte_ff};
               phase_in = cfd_pkg::PH_HUNT;
            end
            default: begin
               phase_in = cfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= cfd_pkg::PH_HUNT;
         cmd_ff       <= 8'd0;
         id_ff        <= 8'd0;
         len_ff       <= 8'd0;
         count_ff     <= 8'd0;
         crc_ff       <= 16'd0;
         elapsed_ff   <= 16'd0;
         timeout_ff   <= cfd_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            cmd_ff     <= cmd_in;
            id_ff      <= id_in;
            len_ff     <= len_in;
            count_ff   <= count_in;
            crc_ff     <= crc_in;
            elapsed_ff <= elapsed_in;
         end
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_data_byte;
      end
      // load the result fields; frame fields are the holds before this item's update
      if (advance && emit) begin
         kind_ff    <= kind_in;
         o_cmd_ff   <= cmd_ff;
         o_id_ff    <= id_ff;
         o_len_ff   <= len_ff;
         o_index_ff <= o_index_in;
         o_byte_ff  <= o_byte_in;
         o_crc_ff   <= o_crc_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_frame_cmd      = o_cmd_ff;
   assign rsp_frame_id       = o_id_ff;
   assign rsp_payload_length = o_len_ff;
   assign rsp_payload_index  = o_index_ff;
   assign rsp_payload_byte   = o_byte_ff;
   assign rsp_frame_crc      = o_crc_ff;

`ifndef SYNTHESIS
   // a payload result always lies inside the declared length
   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff == cfd_pkg::KIND_PAYLOAD) |-> (o_index_ff < o_len_ff))
      else $error("payload index outside declared length");

   // a completed or abandoned frame leaves the parser hunting
   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && kind_in != cfd_pkg::KIND_PAYLOAD)
         |=> (phase_ff == cfd_pkg::PH_HUNT))
      else $error("parser not hunting after frame end");

   // a timeout is only reported once the tick count exceeds the limit
   a_timeout_cause: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && kind_in == cfd_pkg::KIND_TIMEOUT) |=> (elapsed_ff > timeout_ff))
      else $error("timeout reported below limit");

   // a waiting input item is never dropped
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input item lost");

   // a result register that is stalled holds its kind and index
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(kind_ff)
         && $stable(o_index_ff)))
      else $error("stalled result changed");
`endif

endmodule
